>>> sv/bsmc_pkg.sv
// Shared types and constants of the blockwise saturating MAC column.
package bsmc_pkg;

    localparam int ACT_W      = 5;
    localparam int WEIGHT_W   = 7;
    localparam int RESULT_W   = 8;
    localparam int SEND_W     = 8;
    localparam int GAIN_W     = 24;
    localparam int SCALE_W    = SEND_W + GAIN_W;
    localparam int BSUM_W     = 20;
    localparam int TOTAL_W    = 16;
    localparam int PROD_W     = BSUM_W + SCALE_W;
    localparam int FRAC_W     = 16;
    localparam int SHIFTED_W  = PROD_W - FRAC_W;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SEND_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = CFG_INDEX_W'(1);

    localparam logic [SEND_W-1:0] SEND_COUNT_RESET = SEND_W'(1);
    localparam logic [GAIN_W-1:0] GAIN_RESET       = GAIN_W'(65536);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scale_en;
        logic mult_en;
        logic fold_en;
        logic emit_en;
    } bsmc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_at_end;
        logic last_pend;
        logic out_free;
    } bsmc_status_t;

endpackage

>>> sv/bsmc_ctrl.sv
// Controller state machine of the blockwise saturating MAC column.
module bsmc_ctrl
    import bsmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         last,
    input  bsmc_status_t status,
    output logic         in_ready,
    output bsmc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCALE = 5'b00010,
        ST_MULT  = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (last || status.row_at_end)
                    begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult_en = 1'b1;
                state_next  = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold_en = 1'b1;
                state_next  = status.last_pend ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/bsmc_datapath.sv
// Datapath of the blockwise saturating MAC column: accumulate, scale, fold, emit.
module bsmc_datapath
    import bsmc_pkg::*;
#(
    parameter int ROWS_PER_BLOCK = 128,
    parameter int WEIGHT_MAX     = 63
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsmc_cmd_t                   cmd,
    output bsmc_status_t                status,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic [ACT_W-1:0]            activation,
    input  logic signed [WEIGHT_W-1:0]  weight,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [RESULT_W-1:0]  result,
    output logic                        range_error
);

    localparam int ROW_W = (ROWS_PER_BLOCK > 1) ? $clog2(ROWS_PER_BLOCK) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS_PER_BLOCK - 1);
    localparam logic signed [WEIGHT_W:0] WMAX_POS = (WEIGHT_W + 1)'(WEIGHT_MAX);
    localparam logic signed [WEIGHT_W:0] WMAX_NEG = -WMAX_POS;
    localparam int MAC_W = ACT_W + WEIGHT_W + 1;

    logic [SEND_W-1:0]               send_count_reg;
    logic [GAIN_W-1:0]               gain_reg;
    logic [SCALE_W-1:0]              scale_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [BSUM_W-1:0]        block_sum_reg;
    logic signed [TOTAL_W-1:0]       total_reg;
    logic [ROW_W-1:0]                row_reg;
    logic                            error_reg;
    logic                            last_reg;
    logic                            out_valid_reg;
    logic signed [RESULT_W-1:0]      result_reg;
    logic                            range_error_reg;

    logic signed [WEIGHT_W:0]        weight_ext;
    logic signed [MAC_W-1:0]         mac;
    logic signed [PROD_W:0]          prod_full;
    logic signed [SHIFTED_W-1:0]     shifted;
    logic signed [RESULT_W-1:0]      block_i8;
    logic signed [TOTAL_W:0]         total_sum;
    logic signed [TOTAL_W-1:0]       total_next;
    logic signed [RESULT_W-1:0]      total_i8;
    logic                            weight_bad;

    always_comb
    begin
        weight_ext = (WEIGHT_W + 1)'(weight);
        weight_bad = (weight_ext > WMAX_POS) || (weight_ext < WMAX_NEG);
        mac        = $signed({{(MAC_W - ACT_W){1'b0}}, activation}) * MAC_W'(weight);
        prod_full  = $signed(block_sum_reg) * $signed({1'b0, scale_reg});
        // arithmetic shift floors toward minus infinity
        shifted    = SHIFTED_W'(prod_reg >>> FRAC_W);

        if (shifted < -SHIFTED_W'(128))
            block_i8 = -RESULT_W'(128);
        else if (shifted > SHIFTED_W'(127))
            block_i8 = RESULT_W'(127);
        else
            block_i8 = RESULT_W'(shifted);

        total_sum = (TOTAL_W + 1)'(total_reg) + (TOTAL_W + 1)'(block_i8);
        if (total_sum > (TOTAL_W + 1)'(32767))
            total_next = TOTAL_W'(32767);
        else if (total_sum < -(TOTAL_W + 1)'(32768))
            total_next = -TOTAL_W'(32768);
        else
            total_next = TOTAL_W'(total_sum);

        if (total_reg < -TOTAL_W'(128))
            total_i8 = -RESULT_W'(128);
        else if (total_reg > TOTAL_W'(127))
            total_i8 = RESULT_W'(127);
        else
            total_i8 = RESULT_W'(total_reg);
    end

    // accumulation state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_count_reg <= SEND_COUNT_RESET;
            gain_reg       <= GAIN_RESET;
            block_sum_reg  <= '0;
            total_reg      <= '0;
            row_reg        <= '0;
            error_reg      <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SEND_COUNT: send_count_reg <= cfg_data[SEND_W-1:0];
                    REG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                    default:        ;
                endcase
            end

            if (cmd.accept)
            begin
                block_sum_reg <= block_sum_reg + BSUM_W'(mac);
                last_reg      <= last;
                if (weight_bad)
                    error_reg <= 1'b1;
                if (!(last || row_reg == ROW_LAST))
                    row_reg <= row_reg + ROW_W'(1);
            end

            if (cmd.fold_en)
            begin
                total_reg     <= total_next;
                block_sum_reg <= '0;
                row_reg       <= '0;
            end

            if (cmd.emit_en)
            begin
                total_reg     <= '0;
                error_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scaling pipeline and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.scale_en)
            scale_reg <= send_count_reg * gain_reg;
        if (cmd.mult_en)
            prod_reg <= PROD_W'(prod_full);
        if (cmd.emit_en)
        begin
            result_reg      <= total_i8;
            range_error_reg <= error_reg;
        end
    end

    assign status.row_at_end = (row_reg == ROW_LAST);
    assign status.last_pend  = last_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign result      = result_reg;
    assign range_error = range_error_reg;

endmodule

>>> sv/blockwise_saturating_mac_column.sv
// Top level of the blockwise saturating MAC column: controller plus datapath.
//
// Usage: input requests (activation, weight, last) arrive on the in_valid /
// in_ready channel, one product per request. Products add into a block sum;
// after ROWS_PER_BLOCK rows, or at a request marked last, the block sum is
// scaled by send_count * gain_q8_16 / 2^16 (floored), clamped to int8 and
// added to a saturating 16-bit running total. At a request marked last the
// total is clamped to int8 and presented with range_error on out_valid /
// out_ready, and the vector state clears.
// Throughput: one request per cycle inside a block. A block close runs the
// scale product, block multiply and fold steps in order; a last request adds
// an emit step on top to load the output register.
// Stall: the result waits in an output register; accumulation of the next
// vector proceeds, and only the next emit waits for out_ready.
// Configuration: cfg_valid / cfg_ready writes send_count (index 0) or
// gain_q8_16 (index 1); other indexes are dropped. cfg_ready is always high.
// Reset: rst_n clears all accumulation state and restores send_count = 1 and
// gain = 1.0; no output is pending after reset.
module blockwise_saturating_mac_column
    import bsmc_pkg::*;
#(
    parameter int ROWS_PER_BLOCK = 128,
    parameter int WEIGHT_MAX     = 63
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ACT_W-1:0]            activation,
    input  logic signed [WEIGHT_W-1:0]  weight,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [RESULT_W-1:0]  result,
    output logic                        range_error,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    bsmc_cmd_t    cmd;
    bsmc_status_t status;

    // configuration writes never stall
    assign cfg_ready = 1'b1;

    bsmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    bsmc_datapath #(
        .ROWS_PER_BLOCK (ROWS_PER_BLOCK),
        .WEIGHT_MAX     (WEIGHT_MAX)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .activation  (activation),
        .weight      (weight),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result),
        .range_error (range_error)
    );

    // a last request always starts a close sequence, which blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input taken during block close");

    // the fold uses the product registered in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold_en |-> $past(cmd.mult_en))
        else $error("fold without preceding block multiply");

    // a new result is loaded only while input is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_en |-> (!in_ready && $past(cmd.fold_en || cmd.emit_en || !in_ready)))
        else $error("emit outside the close sequence");

endmodule
